### rtl/core/gps_pkg.sv
// Package for the greedy point suppression block.
// Holds payload structs, datapath command codes, controller states and fixed widths.
// No dependencies.
`default_nettype none

package gps_pkg;

  localparam int COORD_W   = 20;
  localparam int WEIGHT_W  = 16;
  localparam int DIAM_W    = 16;
  localparam int SOURCE_W  = 2;
  localparam int RADIUS_W  = 16;
  localparam int REMOVED_W = 6;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int DIST_W    = SQ_W + 2;
  localparam int COORDS_W  = 3 * COORD_W;
  localparam int ATTR_W    = WEIGHT_W + DIAM_W + SOURCE_W;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd590;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic [WEIGHT_W-1:0]       in_weight;
    logic [DIAM_W-1:0]         in_diameter;
    logic [SOURCE_W-1:0]       in_source;
    logic                      in_last;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [WEIGHT_W-1:0]       out_weight;
    logic [DIAM_W-1:0]         out_diameter;
    logic [SOURCE_W-1:0]       out_source;
    logic                      out_last;
    logic [REMOVED_W-1:0]      removed_count;
    logic                      overflow;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_DIFF,
    OP_SQR,
    OP_SUM,
    OP_CMP,
    OP_STEP,
    OP_PICK,
    OP_DROP,
    OP_EMIT_INIT,
    OP_EMIT_LOAD,
    OP_EMIT_SKIP,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic pair_ok;
    logic scan_end;
    logic close;
    logic emit_alive;
    logic emit_end;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_INIT,
    S_SCAN_CHK,
    S_DIFF,
    S_SQR,
    S_SUM,
    S_CMP,
    S_STEP,
    S_DECIDE,
    S_PICK_RD,
    S_DROP,
    S_EMIT_CHK,
    S_EMIT_WAIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/gps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/gps_datapath.sv
// Datapath: point stores, pair indices, distance pipeline, best-pair tracking, result register.
// Depends on gps_pkg and gps_ram.
`default_nettype none

module gps_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire gps_pkg::dp_op_t                 op,
  output gps_pkg::dp_status_t                  status,
  input  wire gps_pkg::in_t                    in_data,
  input  wire logic                            cfg_we,
  input  wire logic [gps_pkg::RADIUS_W-1:0]    cfg_wdata,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output gps_pkg::out_t                        out_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [gps_pkg::RADIUS_W-1:0]  radius_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [MAX_POINTS-1:0]         alive_r, alive_nxt;
  logic [gps_pkg::REMOVED_W-1:0] removed_r, removed_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [CNT_W-1:0]              i_r, i_nxt, j_r, j_nxt, bi_r, bi_nxt, bj_r, bj_nxt;
  logic                          found_r, found_nxt;
  logic [gps_pkg::DIST_W-1:0]    best_r, best_nxt, sum_r;
  logic [gps_pkg::DIFF_W-1:0]    dx_r, dy_r, dz_r;
  logic [gps_pkg::SQ_W-1:0]      sx_r, sy_r, sz_r;
  logic                          out_valid_r, out_valid_nxt;
  gps_pkg::out_t                 out_r;

  logic                          wr_en;
  logic [gps_pkg::COORDS_W-1:0]  coord_a, coord_b, coord_w;
  logic [gps_pkg::ATTR_W-1:0]    attr_a, attr_b, attr_w;
  logic [2*gps_pkg::RADIUS_W-1:0] limit;
  logic [MAX_POINTS-1:0]         above;

  function automatic logic [gps_pkg::DIFF_W-1:0] abs_diff(
    input logic [gps_pkg::COORD_W-1:0] a,
    input logic [gps_pkg::COORD_W-1:0] b
  );
    logic signed [gps_pkg::DIFF_W-1:0] d;
    d = $signed({a[gps_pkg::COORD_W-1], a}) - $signed({b[gps_pkg::COORD_W-1], b});
    abs_diff = d[gps_pkg::DIFF_W-1] ? gps_pkg::DIFF_W'(-d) : gps_pkg::DIFF_W'(d);
  endfunction

  assign wr_en   = (op == gps_pkg::OP_LOAD) && (count_r < CNT_W'(MAX_POINTS));
  assign coord_w = {in_data.in_x, in_data.in_y, in_data.in_z};
  assign attr_w  = {in_data.in_weight, in_data.in_diameter, in_data.in_source};

  gps_ram #(.WIDTH(gps_pkg::COORDS_W), .DEPTH(MAX_POINTS)) u_coord_a (
    .clk, .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(coord_w),
    .raddr(i_r[IDX_W-1:0]), .rdata(coord_a)
  );
  gps_ram #(.WIDTH(gps_pkg::COORDS_W), .DEPTH(MAX_POINTS)) u_coord_b (
    .clk, .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(coord_w),
    .raddr(j_r[IDX_W-1:0]), .rdata(coord_b)
  );
  gps_ram #(.WIDTH(gps_pkg::ATTR_W), .DEPTH(MAX_POINTS)) u_attr_a (
    .clk, .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(attr_w),
    .raddr(i_r[IDX_W-1:0]), .rdata(attr_a)
  );
  gps_ram #(.WIDTH(gps_pkg::ATTR_W), .DEPTH(MAX_POINTS)) u_attr_b (
    .clk, .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(attr_w),
    .raddr(j_r[IDX_W-1:0]), .rdata(attr_b)
  );

  assign limit = radius_r * radius_r;
  assign above = (alive_r >> i_r) >> 1;

  always_comb begin
    status.pair_ok    = alive_r[i_r[IDX_W-1:0]] && alive_r[j_r[IDX_W-1:0]];
    status.scan_end   = ({1'b0, i_r} + (CNT_W+1)'(1)) >= {1'b0, count_r};
    status.close      = found_r && (gps_pkg::DIST_W'(limit) > best_r);
    status.emit_alive = alive_r[i_r[IDX_W-1:0]];
    status.emit_end   = i_r >= count_r;
    status.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    count_nxt     = count_r;
    alive_nxt     = alive_r;
    removed_nxt   = removed_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    bi_nxt        = bi_r;
    bj_nxt        = bj_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (op)
      gps_pkg::OP_LOAD: begin
        if (wr_en) begin
          alive_nxt[count_r[IDX_W-1:0]] = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      gps_pkg::OP_SCAN_INIT: begin
        i_nxt     = '0;
        j_nxt     = CNT_W'(1);
        found_nxt = 1'b0;
      end
      gps_pkg::OP_CMP: begin
        if (!found_r || (sum_r < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = sum_r;
          bi_nxt    = i_r;
          bj_nxt    = j_r;
        end
      end
      gps_pkg::OP_STEP: begin
        if (({1'b0, j_r} + (CNT_W+1)'(1)) < {1'b0, count_r}) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          i_nxt = i_r + CNT_W'(1);
          j_nxt = CNT_W'({1'b0, i_r} + (CNT_W+1)'(2));
        end
      end
      gps_pkg::OP_PICK: begin
        i_nxt = bi_r;
        j_nxt = bj_r;
      end
      gps_pkg::OP_DROP: begin
        // drop the lighter point, or the lower index on a tie
        if (attr_a[gps_pkg::ATTR_W-1 -: gps_pkg::WEIGHT_W] >
            attr_b[gps_pkg::ATTR_W-1 -: gps_pkg::WEIGHT_W]) begin
          alive_nxt[j_r[IDX_W-1:0]] = 1'b0;
        end else begin
          alive_nxt[i_r[IDX_W-1:0]] = 1'b0;
        end
        removed_nxt = removed_r + gps_pkg::REMOVED_W'(1);
      end
      gps_pkg::OP_EMIT_INIT: i_nxt = '0;
      gps_pkg::OP_EMIT_LOAD: begin
        out_valid_nxt = 1'b1;
        i_nxt = i_r + CNT_W'(1);
      end
      gps_pkg::OP_EMIT_SKIP: i_nxt = i_r + CNT_W'(1);
      gps_pkg::OP_CLEAR: begin
        alive_nxt   = '0;
        count_nxt   = '0;
        removed_nxt = '0;
        ovf_nxt     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= gps_pkg::RADIUS_RESET;
      count_r     <= '0;
      alive_r     <= '0;
      removed_r   <= '0;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      alive_r     <= alive_nxt;
      removed_r   <= removed_nxt;
      ovf_r       <= ovf_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bi_r   <= bi_nxt;
    bj_r   <= bj_nxt;
    best_r <= best_nxt;
    if (op == gps_pkg::OP_DIFF) begin
      dx_r <= abs_diff(coord_a[3*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W],
                       coord_b[3*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W]);
      dy_r <= abs_diff(coord_a[2*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W],
                       coord_b[2*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W]);
      dz_r <= abs_diff(coord_a[gps_pkg::COORD_W-1:0], coord_b[gps_pkg::COORD_W-1:0]);
    end
    if (op == gps_pkg::OP_SQR) begin
      sx_r <= dx_r * dx_r;
      sy_r <= dy_r * dy_r;
      sz_r <= dz_r * dz_r;
    end
    if (op == gps_pkg::OP_SUM) begin
      sum_r <= gps_pkg::DIST_W'(sx_r) + gps_pkg::DIST_W'(sy_r) + gps_pkg::DIST_W'(sz_r);
    end
    if (op == gps_pkg::OP_EMIT_LOAD) begin
      out_r.out_x         <= coord_a[3*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W];
      out_r.out_y         <= coord_a[2*gps_pkg::COORD_W-1 -: gps_pkg::COORD_W];
      out_r.out_z         <= coord_a[gps_pkg::COORD_W-1:0];
      out_r.out_weight    <= attr_a[gps_pkg::ATTR_W-1 -: gps_pkg::WEIGHT_W];
      out_r.out_diameter  <= attr_a[gps_pkg::SOURCE_W +: gps_pkg::DIAM_W];
      out_r.out_source    <= attr_a[gps_pkg::SOURCE_W-1:0];
      out_r.out_last      <= ~|above;
      out_r.removed_count <= removed_r;
      out_r.overflow      <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/core/gps_ctrl.sv
// Controller state machine: sequences load, pair scan passes, suppression and emission.
// Depends on gps_pkg.
`default_nettype none

module gps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire gps_pkg::dp_status_t status,
  output gps_pkg::dp_op_t          op
);

  gps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = gps_pkg::OP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      gps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = gps_pkg::OP_LOAD;
          if (in_last) begin
            state_nxt = gps_pkg::S_SCAN_INIT;
          end
        end
      end
      gps_pkg::S_SCAN_INIT: begin
        op        = gps_pkg::OP_SCAN_INIT;
        state_nxt = gps_pkg::S_SCAN_CHK;
      end
      gps_pkg::S_SCAN_CHK: begin
        if (status.scan_end) begin
          state_nxt = gps_pkg::S_DECIDE;
        end else if (status.pair_ok) begin
          state_nxt = gps_pkg::S_DIFF;
        end else begin
          op = gps_pkg::OP_STEP;
        end
      end
      gps_pkg::S_DIFF: begin
        op        = gps_pkg::OP_DIFF;
        state_nxt = gps_pkg::S_SQR;
      end
      gps_pkg::S_SQR: begin
        op        = gps_pkg::OP_SQR;
        state_nxt = gps_pkg::S_SUM;
      end
      gps_pkg::S_SUM: begin
        op        = gps_pkg::OP_SUM;
        state_nxt = gps_pkg::S_CMP;
      end
      gps_pkg::S_CMP: begin
        op        = gps_pkg::OP_CMP;
        state_nxt = gps_pkg::S_STEP;
      end
      gps_pkg::S_STEP: begin
        op        = gps_pkg::OP_STEP;
        state_nxt = gps_pkg::S_SCAN_CHK;
      end
      gps_pkg::S_DECIDE: begin
        if (status.close) begin
          op        = gps_pkg::OP_PICK;
          state_nxt = gps_pkg::S_PICK_RD;
        end else begin
          op        = gps_pkg::OP_EMIT_INIT;
          state_nxt = gps_pkg::S_EMIT_CHK;
        end
      end
      gps_pkg::S_PICK_RD: state_nxt = gps_pkg::S_DROP;
      gps_pkg::S_DROP: begin
        op        = gps_pkg::OP_DROP;
        state_nxt = gps_pkg::S_SCAN_INIT;
      end
      gps_pkg::S_EMIT_CHK: begin
        if (status.emit_end) begin
          op        = gps_pkg::OP_CLEAR;
          state_nxt = gps_pkg::S_IDLE;
        end else if (status.emit_alive) begin
          state_nxt = gps_pkg::S_EMIT_WAIT;
        end else begin
          op = gps_pkg::OP_EMIT_SKIP;
        end
      end
      gps_pkg::S_EMIT_WAIT: begin
        if (status.out_free) begin
          op        = gps_pkg::OP_EMIT_LOAD;
          state_nxt = gps_pkg::S_EMIT_CHK;
        end
      end
      default: state_nxt = gps_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/greedy_point_suppression.sv
// Greedy point suppression: loads a point set, removes close pairs pass by pass, emits survivors.
// Input beats are accepted one per cycle while idle. Each pass scans up to 2016 pairs and runs
// the distance unit on every pair whose points are both alive; a pass that finds a close pair
// drops one point (up to 63 such passes). Emission skips dropped points and waits on the receiver.
// Sets are taken one at a time: input is closed until the set is emitted.
// Reset (rst_n, synchronous, active low): empty set, radius 590, no result pending.
`default_nettype none

module greedy_point_suppression #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input point beats
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire gps_pkg::in_t                 in_data,
  // surviving point beats
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output gps_pkg::out_t                     out_data,
  // merge radius register
  input  wire logic                         cfg_we,
  input  wire logic [gps_pkg::RADIUS_W-1:0] cfg_wdata
);

  gps_pkg::dp_op_t     op;
  gps_pkg::dp_status_t status;

  // sequence the passes; from the datapath the controller only sees status flags
  gps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_last(in_data.in_last), .in_ready, .status, .op
  );

  // hold points, run the distance unit, track the best pair, drive result beats
  gps_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst_n, .op, .status, .in_data, .cfg_we, .cfg_wdata,
    .out_valid, .out_ready, .out_data
  );

  // a last beat starts filtering, so input must close
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.in_last |=> !in_ready)
    else $error("input still open after last beat");

  // hold a result beat, unchanged, until it is taken
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed before it was taken");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
